// File: hdl/eti_pkg.sv
// eti_pkg: shared widths, codes, register reset values and word types for the
// envelope trough inserter. No dependencies.
`default_nettype none

package eti_pkg;

    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    // fade = (stroke << 23) / (65536 - trough) fits 39 bits; twice it fits 40
    localparam int DIV_W     = 40;
    localparam int STEP_W    = 6;
    localparam int FADE_SHIFT = 23;
    localparam int DEN_W     = CFG_W + 1;

    localparam logic [STEP_W-1:0] FADE_STEPS = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(LEVEL_W);

    localparam logic [CFG_IDX_W-1:0] CFG_TROUGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROKE = 1'b1;

    localparam logic [CFG_W-1:0] TROUGH_RST = 16'd32768;
    localparam logic [CFG_W-1:0] STROKE_RST = 16'd1000;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0]  peak_time;
        logic [LEVEL_W-1:0] peak_level;
        logic               final_peak;
    } t_in_word;

    typedef struct packed {
        logic [TIME_W-1:0]  point_time;
        logic [LEVEL_W-1:0] point_level;
        logic               is_peak;
        logic               run_end;
    } t_out_word;

    // one division job for the shared divider
    typedef struct packed {
        logic [DIV_W-1:0]  rem0;
        logic [DIV_W-1:0]  quo0;
        logic [DIV_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

// File: hdl/eti_div.sv
// eti_div: restoring divider, one quotient bit per cycle, shared by the fade
// time and the trough fraction. Depends on eti_pkg.
`default_nettype none

module eti_div
    import eti_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_div_req         i_req,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0] w_sh;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    // dividend bits enter the remainder from the top of the quotient register
    assign w_sh   = {r_rem, r_quo[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_req.rem0;
                r_quo  <= i_req.quo0;
                r_den  <= i_req.den;
                r_cnt  <= i_req.steps;
                r_busy <= i_req.steps != '0;
                r_done <= i_req.steps == '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with zero step count");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_req.steps != '0) |=> (r_busy || r_done))
        else $error("divider did not start");

endmodule

`default_nettype wire

// File: hdl/envelope_trough_inserter_core.sv
// envelope_trough_inserter_core: top level, sequencer and output register.
// Depends on eti_pkg and eti_div.
//
// Input channel: one peak word (time, level, final flag) on i_in_valid /
// o_in_stall. Output channel: waypoint words on o_out_valid / i_out_stall,
// in time order: inserted troughs, the peak itself, then the trailing zero
// after a final peak. run_end marks the last word caused by one peak.
// Config: i_cfg_we writes trough_level (index 0) or max_stroke_ms (index 1).
// After reset and after every config write the fade time is recomputed on
// the shared divider in 40 steps; no peak is taken until it is ready.
// Per peak: accept, then gap/sums/product, then plan, then one word per cycle
// while the receiver does not stall (1 to 4 words). A midpoint trough whose gap
// is at least 256 times the stroke value takes the divider for 16 steps before
// emission; such a peak gives 2 or 3 words.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; the next peak is taken once all words are loaded.
// Reset clears the previous-peak state and restores the register defaults.
`default_nettype none

module envelope_trough_inserter_core
    import eti_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_FADE, S_GAP, S_PLAN, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_LEAD, PH_SECOND, PH_PEAK, PH_TRAIL
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [CFG_W-1:0]   r_trough;
    logic [CFG_W-1:0]   r_stroke;
    logic [DIV_W-1:0]   r_fade;
    logic               r_fade_ok;

    logic [TIME_W-1:0]  r_prev_t;
    logic [LEVEL_W-1:0] r_prev_l;
    logic               r_have_prev;

    t_in_word           r_cur;
    logic [TIME_W-1:0]  r_gap;
    logic [TIME_W-1:0]  r_mid;
    logic [TIME_W-1:0]  r_tfar;
    logic [TIME_W-1:0]  r_ta;
    logic [TIME_W-1:0]  r_tb;
    logic [TIME_W-1:0]  r_tc;
    logic [LEVEL_W-1:0] r_la;
    logic [LEVEL_W-1:0] r_prod;
    logic               r_eb;

    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_in_acc;
    logic               w_slot_free;
    logic [DIV_W-1:0]   w_two_fade;
    logic [DIV_W-1:0]   w_cur_x;
    logic [DIV_W-1:0]   w_prev_x;
    logic [DIV_W-1:0]   w_sum_cur;
    logic [DIV_W-1:0]   w_sum_prev;
    logic [TIME_W:0]    w_mid_sum;
    logic [LEVEL_W-1:0] w_max_l;
    logic [LEVEL_W+CFG_W-1:0] w_prod;
    logic [DEN_W-1:0]   w_fade_den;
    logic               w_gap_gt;
    logic               w_gap_short;
    logic               w_need_frac;
    logic               w_div_start;
    t_div_req           w_div_req;
    logic               w_div_busy;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    t_out_word          w_emit;
    logic               w_last;
    t_phase             w_next_ph;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_two_fade  = {r_fade[DIV_W-2:0], 1'b0};
    assign w_cur_x     = DIV_W'(r_cur.peak_time);
    assign w_prev_x    = DIV_W'(r_prev_t);
    assign w_sum_cur   = w_cur_x + r_fade;
    assign w_sum_prev  = w_prev_x + r_fade;
    assign w_mid_sum   = {1'b0, r_prev_t} + {1'b0, r_cur.peak_time};
    assign w_max_l     = (r_prev_l > r_cur.peak_level) ? r_prev_l : r_cur.peak_level;
    assign w_prod      = w_max_l * r_trough;
    assign w_fade_den  = DEN_W'(17'h10000) - {1'b0, r_trough};

    assign w_gap_gt    = DIV_W'(r_gap) > w_two_fade;
    assign w_gap_short = r_gap < TIME_W'({r_stroke, 8'h00});
    assign w_need_frac = (r_state == S_PLAN) && r_have_prev && !w_gap_gt
                         && !w_gap_short && (r_gap != '0);
    assign w_div_start = ((r_state == S_IDLE) && !r_fade_ok && !i_cfg_we) || w_need_frac;

    always_comb begin
        w_div_req = '0;
        if (r_state == S_PLAN) begin
            w_div_req.rem0  = w_two_fade - DIV_W'(r_gap);
            w_div_req.quo0  = '0;
            w_div_req.den   = w_two_fade;
            w_div_req.steps = FRAC_STEPS;
        end else begin
            w_div_req.rem0  = '0;
            w_div_req.quo0  = {1'b0, r_stroke, FADE_SHIFT'(0)};
            w_div_req.den   = DIV_W'(w_fade_den);
            w_div_req.steps = FADE_STEPS;
        end
    end

    eti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // word for the current emission phase
    always_comb begin
        w_emit    = '0;
        w_last    = 1'b0;
        w_next_ph = PH_PEAK;
        case (r_phase)
            PH_LEAD: begin
                w_emit.point_time  = r_ta;
                w_emit.point_level = r_la;
                w_next_ph          = r_eb ? PH_SECOND : PH_PEAK;
            end
            PH_SECOND: begin
                w_emit.point_time = r_tb;
                w_next_ph         = PH_PEAK;
            end
            PH_PEAK: begin
                w_emit.point_time  = r_cur.peak_time;
                w_emit.point_level = r_cur.peak_level;
                w_emit.is_peak     = 1'b1;
                w_last             = !r_cur.final_peak;
                w_next_ph          = PH_TRAIL;
            end
            PH_TRAIL: begin
                w_emit.point_time = r_tc;
                w_last            = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
        w_emit.run_end = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_PEAK;
            r_trough    <= TROUGH_RST;
            r_stroke    <= STROKE_RST;
            r_fade_ok   <= 1'b0;
            r_prev_t    <= '0;
            r_prev_l    <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_div_start) begin
                        r_state <= S_FADE;
                    end else if (w_in_acc) begin
                        r_cur   <= i_in_word;
                        r_state <= S_GAP;
                    end
                end
                S_FADE: begin
                    if (i_cfg_we) begin
                        r_state <= S_IDLE;
                    end else if (w_div_done) begin
                        r_fade    <= w_div_quo;
                        r_fade_ok <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_GAP: begin
                    r_gap   <= (r_cur.peak_time > r_prev_t) ? r_cur.peak_time - r_prev_t : '0;
                    r_mid   <= w_mid_sum[TIME_W:1];
                    r_prod  <= w_prod[LEVEL_W+CFG_W-1:CFG_W];
                    r_tb    <= (w_cur_x > r_fade) ? TIME_W'(w_cur_x - r_fade) : '0;
                    r_tc    <= (w_sum_cur > DIV_W'(TIME_MAX)) ? TIME_MAX
                                                              : w_sum_cur[TIME_W-1:0];
                    r_tfar  <= (w_sum_prev > DIV_W'(TIME_MAX)) ? TIME_MAX
                                                               : w_sum_prev[TIME_W-1:0];
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_eb    <= 1'b0;
                    r_la    <= '0;
                    r_phase <= PH_LEAD;
                    r_state <= S_EMIT;
                    if (!r_have_prev) begin
                        r_ta <= r_tb;
                        if (r_cur.peak_time == '0) begin
                            r_phase <= PH_PEAK;
                        end
                    end else if (w_gap_gt) begin
                        r_ta <= r_tfar;
                        r_eb <= 1'b1;
                    end else begin
                        r_ta <= r_mid;
                        if (w_gap_short) begin
                            r_la <= r_prod;
                        end else if (r_gap == '0) begin
                            // zero divisor case: fraction saturates
                            r_la <= LEVEL_MAX;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_la    <= w_div_quo[LEVEL_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out       <= w_emit;
                        r_out_valid <= 1'b1;
                        r_phase     <= w_next_ph;
                        if (w_last) begin
                            r_state <= S_IDLE;
                            if (r_cur.final_peak) begin
                                r_have_prev <= 1'b0;
                                r_prev_t    <= '0;
                                r_prev_l    <= '0;
                            end else begin
                                r_have_prev <= 1'b1;
                                r_prev_t    <= r_cur.peak_time;
                                r_prev_l    <= r_cur.peak_level;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                r_fade_ok <= 1'b0;
                case (i_cfg_idx)
                    CFG_TROUGH: r_trough <= i_cfg_data;
                    CFG_STROKE: r_stroke <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && r_fade_ok);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_acc_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_GAP)
        else $error("accepted word did not start processing");
    // while the trailing word waits, a held peak word belongs to the current peak
    a_peak_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_peak && r_state == S_EMIT && r_phase == PH_TRAIL)
        |-> r_out.point_time == r_cur.peak_time)
        else $error("peak word time differs from held peak");
    a_fade_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FADE && !i_cfg_we && w_div_done) |=> r_fade_ok)
        else $error("fade time not marked ready");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !w_div_done) |-> w_div_busy)
        else $error("waiting on idle divider");

endmodule

`default_nettype wire
